/* hw/rtl/pffa_pkg.sv */
// ----------------------------------------------------------------------------
// Page frame FIFO allocator package
// Shared types, codes and constants of the page frame allocator.
// ----------------------------------------------------------------------------
package pffa_pkg;

    localparam int PFFA_PAGE_SLOTS = 4096;
    localparam int PFFA_FRAME_BITS = 40;

    localparam int PFFA_ADDR_W    = 64;
    localparam int PFFA_REGION_W  = 40;
    localparam int PFFA_SIZE_W    = 32;
    localparam int PFFA_FPC_W     = 13;
    localparam int PFFA_PAGE_SHIFT = 12;
    localparam int PFFA_PAGE_BYTES = 4096;
    // Sixteen-byte descriptors: 256 of them fill one page.
    localparam int PFFA_DESC_SHIFT = 8;
    localparam int PFFA_PAGES_W   = PFFA_SIZE_W - PFFA_PAGE_SHIFT + 1;

    localparam logic [PFFA_ADDR_W-1:0] PFFA_KERNEL_BASE_RST = 64'hFFFF_FFFF_8000_0000;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        VIEW_KMAP   = 2'd0,
        VIEW_KUNMAP = 2'd1,
        VIEW_USER   = 2'd2,
        VIEW_PHYS   = 2'd3
    } t_view;

    typedef enum logic [1:0] {
        CFG_FIRST_FRAME = 2'd0,
        CFG_END_FRAME   = 2'd1,
        CFG_KERNEL_BASE = 2'd2,
        CFG_USER_BASE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_op                    operation;
        logic [PFFA_SIZE_W-1:0] alloc_size;
        t_view                  address_view;
        logic [PFFA_ADDR_W-1:0] release_address;
    } t_req;

    typedef struct packed {
        logic [PFFA_ADDR_W-1:0] result_address;
        logic                   granted;
        logic                   map_request;
        logic                   unmap_request;
        logic [PFFA_FPC_W-1:0]  free_page_count;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_K,
        ST_INIT_DROP,
        ST_INIT_LOAD,
        ST_INIT_FILL,
        ST_ALLOC_READ,
        ST_ALLOC_UPDATE,
        ST_REL_STRIP,
        ST_REL_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic init_k;
        logic init_drop;
        logic init_load;
        logic init_fill;
        logic init_finish;
        logic alloc_read;
        logic alloc_update;
        logic rel_strip;
        logic rel_write;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic fill_done;
    } t_stat;

endpackage

/* hw/rtl/pffa_req_if.sv */
// ----------------------------------------------------------------------------
// Page frame allocator request channel
// Valid/ready channel that carries one allocator request.
// ----------------------------------------------------------------------------
interface pffa_req_if import pffa_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/pffa_rsp_if.sv */
// ----------------------------------------------------------------------------
// Page frame allocator response channel
// Valid/ready channel that carries one allocator response.
// ----------------------------------------------------------------------------
interface pffa_rsp_if import pffa_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/pffa_ctrl.sv */
// ----------------------------------------------------------------------------
// Page frame allocator controller
// Sequences each request through the datapath and owns the response valid.
// ----------------------------------------------------------------------------
module pffa_ctrl import pffa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_op   i_in_op,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_op)
                        OP_INIT:    n_state = ST_INIT_K;
                        OP_ALLOC:   n_state = ST_ALLOC_READ;
                        OP_RELEASE: n_state = ST_REL_STRIP;
                        OP_NOP:     n_state = ST_DONE;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_INIT_K:       n_state = ST_INIT_DROP;
            ST_INIT_DROP:    n_state = ST_INIT_LOAD;
            ST_INIT_LOAD:    n_state = ST_INIT_FILL;
            ST_INIT_FILL: begin
                if (i_stat.fill_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_ALLOC_READ:   n_state = ST_ALLOC_UPDATE;
            ST_ALLOC_UPDATE: n_state = ST_DONE;
            ST_REL_STRIP:    n_state = ST_REL_WRITE;
            ST_REL_WRITE:    n_state = ST_DONE;
            ST_DONE: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:         n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:         o_cmd.accept       = i_in_valid;
            ST_INIT_K:       o_cmd.init_k       = 1'b1;
            ST_INIT_DROP:    o_cmd.init_drop    = 1'b1;
            ST_INIT_LOAD:    o_cmd.init_load    = 1'b1;
            ST_INIT_FILL: begin
                o_cmd.init_fill   = !i_stat.fill_done;
                o_cmd.init_finish = i_stat.fill_done;
            end
            ST_ALLOC_READ:   o_cmd.alloc_read   = 1'b1;
            ST_ALLOC_UPDATE: o_cmd.alloc_update = 1'b1;
            ST_REL_STRIP:    o_cmd.rel_strip    = 1'b1;
            ST_REL_WRITE:    o_cmd.rel_write    = 1'b1;
            ST_DONE:         o_cmd.out_load     = slot_free;
            default:         o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/pffa_datapath.sv */
// ----------------------------------------------------------------------------
// Page frame allocator datapath
// Configuration registers, frame ring memory, ring pointers and result logic.
// ----------------------------------------------------------------------------
module pffa_datapath import pffa_pkg::*; #(
    parameter int PAGE_SLOTS = PFFA_PAGE_SLOTS,
    parameter int FRAME_BITS = PFFA_FRAME_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  t_req                   i_req,
    input  logic                   i_cfg_we,
    input  t_cfg_idx               i_cfg_index,
    input  logic [PFFA_ADDR_W-1:0] i_cfg_data,
    output t_rsp                   o_rsp
);

    localparam int IDX_W = $clog2(PAGE_SLOTS);
    localparam int CNT_W = $clog2(PAGE_SLOTS + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (PFFA_PAGES_W > CNT_W) ? PFFA_PAGES_W : CNT_W;

    // Configuration.
    logic [PFFA_REGION_W-1:0] r_first_frame;
    logic [PFFA_REGION_W-1:0] r_end_frame;
    logic [PFFA_ADDR_W-1:0]   r_kernel_base;
    logic [PFFA_ADDR_W-1:0]   r_user_base;

    // Ring state.
    logic [FRAME_BITS-1:0] r_ring [PAGE_SLOTS];
    logic [IDX_W-1:0]      r_pop;
    logic [IDX_W-1:0]      r_push;
    logic [CNT_W-1:0]      r_free;

    // Request and working registers.
    logic [PFFA_PAGES_W-1:0]  r_pages;
    t_view                    r_view;
    logic [PFFA_ADDR_W-1:0]   r_rel;
    logic [PFFA_REGION_W-1:0] r_k;
    logic [PFFA_REGION_W-1:0] r_drop;
    logic [CNT_W-1:0]         r_load;
    logic [CNT_W-1:0]         r_fill;
    logic [PFFA_REGION_W-1:0] r_frame;
    logic [FRAME_BITS-1:0]    r_rd_frame;
    logic                     r_grant;
    logic [PFFA_ADDR_W-1:0]   r_phys;

    // Result registers.
    logic [PFFA_ADDR_W-1:0] r_res_addr;
    logic                   r_res_grant;
    logic                   r_res_map;
    logic                   r_res_unmap;
    t_rsp                   r_out;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [FRAME_BITS-1:0]    wr_data;
    logic [PFFA_REGION_W-1:0] avail;
    logic [PFFA_SIZE_W:0]     size_round;
    logic [PFFA_REGION_W:0]   k_round;
    logic [PFFA_ADDR_W-1:0]   alloc_phys;
    logic [PFFA_ADDR_W-1:0]   alloc_addr;
    logic                     alloc_map;
    logic [CNT_W-1:0]         pop_step;
    logic [SUM_W-1:0]         pop_sum;
    logic [IDX_W-1:0]         pop_next;
    logic [IDX_W-1:0]         push_next;
    logic [IDX_W-1:0]         init_push;
    logic [PFFA_ADDR_W-1:0]   strip_phys;

    assign o_stat.fill_done = (r_fill == r_load);
    assign o_rsp            = r_out;

    assign size_round = (PFFA_SIZE_W + 1)'(i_req.alloc_size)
                      + (PFFA_SIZE_W + 1)'(PFFA_PAGE_BYTES - 1);
    assign k_round    = (PFFA_REGION_W + 1)'(r_k)
                      + (PFFA_REGION_W + 1)'((1 << PFFA_DESC_SHIFT) - 1);
    assign avail      = r_k - r_drop;

    // A grant never exceeds the free count, so only a full-ring pop wraps to zero.
    assign pop_step = (CMP_W'(r_pages) == CMP_W'(PAGE_SLOTS)) ? '0 : CNT_W'(r_pages);
    assign pop_sum  = SUM_W'(r_pop) + SUM_W'(pop_step);
    assign pop_next = (pop_sum >= SUM_W'(PAGE_SLOTS)) ? IDX_W'(pop_sum - SUM_W'(PAGE_SLOTS))
                                                     : IDX_W'(pop_sum);
    assign push_next = (r_push == IDX_W'(PAGE_SLOTS - 1)) ? '0 : r_push + 1'b1;
    assign init_push = (r_load == CNT_W'(PAGE_SLOTS)) ? '0 : IDX_W'(r_load);

    assign alloc_phys = PFFA_ADDR_W'(r_rd_frame) << PFFA_PAGE_SHIFT;

    always_comb begin
        alloc_map = 1'b0;
        case (r_view)
            VIEW_KMAP: begin
                alloc_addr = alloc_phys + r_kernel_base;
                alloc_map  = 1'b1;
            end
            VIEW_KUNMAP: alloc_addr = alloc_phys + r_kernel_base;
            VIEW_USER:   alloc_addr = alloc_phys + r_user_base;
            VIEW_PHYS:   alloc_addr = alloc_phys;
            default:     alloc_addr = alloc_phys;
        endcase
    end

    // Kernel base wins when both bases match the released address.
    always_comb begin
        if ((r_rel & r_kernel_base) == r_kernel_base) begin
            strip_phys = r_rel - r_kernel_base;
        end else if ((r_rel & r_user_base) == r_user_base) begin
            strip_phys = r_rel - r_user_base;
        end else begin
            strip_phys = r_rel;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_fill[IDX_W-1:0];
        wr_data = FRAME_BITS'(r_frame);
        if (i_cmd.init_fill) begin
            wr_en = 1'b1;
        end else if (i_cmd.rel_write && r_grant) begin
            wr_en   = 1'b1;
            wr_addr = r_push;
            wr_data = r_phys[PFFA_PAGE_SHIFT +: FRAME_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= wr_data;
        end
        if (i_cmd.alloc_read) begin
            r_rd_frame <= r_ring[r_pop];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_frame <= '0;
            r_end_frame   <= '0;
            r_kernel_base <= PFFA_KERNEL_BASE_RST;
            r_user_base   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_FRAME: r_first_frame <= i_cfg_data[PFFA_REGION_W-1:0];
                CFG_END_FRAME:   r_end_frame   <= i_cfg_data[PFFA_REGION_W-1:0];
                CFG_KERNEL_BASE: r_kernel_base <= i_cfg_data;
                CFG_USER_BASE:   r_user_base   <= i_cfg_data;
                default:         r_user_base   <= r_user_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop  <= '0;
            r_push <= '0;
            r_free <= '0;
            r_load <= '0;
            r_fill <= '0;
        end else begin
            if (i_cmd.init_load) begin
                r_load <= (avail > PFFA_REGION_W'(PAGE_SLOTS)) ? CNT_W'(PAGE_SLOTS)
                                                               : CNT_W'(avail);
                r_fill <= '0;
            end
            if (i_cmd.init_fill) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.init_finish) begin
                r_pop  <= '0;
                r_push <= init_push;
                r_free <= r_load;
            end
            if (i_cmd.alloc_update && r_grant) begin
                r_pop  <= pop_next;
                r_free <= r_free - CNT_W'(r_pages);
            end
            if (i_cmd.rel_write && r_grant) begin
                r_push <= push_next;
                r_free <= r_free + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pages     <= PFFA_PAGES_W'(size_round >> PFFA_PAGE_SHIFT);
            r_view      <= i_req.address_view;
            r_rel       <= i_req.release_address;
            r_res_addr  <= '0;
            r_res_grant <= 1'b0;
            r_res_map   <= 1'b0;
            r_res_unmap <= 1'b0;
        end
        if (i_cmd.init_k) begin
            r_k <= (r_end_frame > r_first_frame) ? r_end_frame - r_first_frame : '0;
        end
        if (i_cmd.init_drop) begin
            r_drop <= PFFA_REGION_W'(k_round >> PFFA_DESC_SHIFT);
        end
        if (i_cmd.init_load) begin
            r_frame <= r_first_frame + r_drop;
        end
        if (i_cmd.init_fill) begin
            r_frame <= r_frame + 1'b1;
        end
        if (i_cmd.init_finish) begin
            r_res_grant <= 1'b1;
        end
        if (i_cmd.alloc_read) begin
            r_grant <= (CMP_W'(r_pages) <= CMP_W'(r_free));
        end
        if (i_cmd.alloc_update && r_grant) begin
            r_res_addr  <= alloc_addr;
            r_res_grant <= 1'b1;
            r_res_map   <= alloc_map;
        end
        if (i_cmd.rel_strip) begin
            r_phys  <= strip_phys;
            r_grant <= (r_free < CNT_W'(PAGE_SLOTS));
        end
        if (i_cmd.rel_write && r_grant) begin
            r_res_addr  <= r_rel;
            r_res_grant <= 1'b1;
            r_res_unmap <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.result_address  <= r_res_addr;
            r_out.granted         <= r_res_grant;
            r_out.map_request     <= r_res_map;
            r_out.unmap_request   <= r_res_unmap;
            r_out.free_page_count <= PFFA_FPC_W'(r_free);
        end
    end

endmodule

/* hw/rtl/page_frame_fifo_allocator.sv */
// ----------------------------------------------------------------------------
// Page frame FIFO allocator
// Free list of 4 KiB page frames kept in a circular ring of frame numbers.
// ----------------------------------------------------------------------------
// Requests arrive on i_req (valid/ready); each one produces exactly one
// response on o_rsp. Operation init loads the configured region into the
// ring, allocate pops whole pages and returns the first page's address,
// release strips the kernel or user base and pushes the frame back.
// The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) writes the region
// bounds and the two base offsets; write it only while no request is in flight.
// Allocate passes through the ring read and update states and release through
// the strip and write states before the response register loads. Allocate
// spends one of them on the registered ring read and release one on stripping
// the base before the ring write. Init steps through the region size, the
// descriptor drop and the load count, then writes up to PAGE_SLOTS frames
// into the ring one entry per cycle. One request is in flight at a time and
// the next one is accepted in the cycle after a response is loaded.
// The response sits in an output register, so a request is accepted while the
// previous response still waits; a stalled receiver holds the next response in
// the datapath until the output register frees up.
// Synchronous reset clears the pointers and the free count and restores the
// default bases; the ring contents are undefined until an init writes them.
// ----------------------------------------------------------------------------
module page_frame_fifo_allocator import pffa_pkg::*; #(
    parameter int PAGE_SLOTS = PFFA_PAGE_SLOTS,
    parameter int FRAME_BITS = PFFA_FRAME_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    pffa_req_if.sink               i_req,
    pffa_rsp_if.source             o_rsp,
    input  logic                   i_cfg_we,
    input  t_cfg_idx               i_cfg_index,
    input  logic [PFFA_ADDR_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    pffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_op     (i_req.data.operation),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pffa_datapath #(
        .PAGE_SLOTS (PAGE_SLOTS),
        .FRAME_BITS (FRAME_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req       (i_req.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rsp       (o_rsp.data)
    );

endmodule
